[rtl/lfu_key_value_cache_macros.svh]
// Assertion macros for the LFU key/value cache checker.
// Used by lfu_kv_checker; expects signals named clk and rst in scope.
`ifndef LFU_KEY_VALUE_CACHE_MACROS_SVH
`define LFU_KEY_VALUE_CACHE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LFU_KV_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lfu_kv: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define LFU_KV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lfu_kv: next-cycle check failed");

`endif

[rtl/lfu_kv_pkg.sv]
// Shared types and constants for the LFU key/value cache.
// No dependencies; the store, scan unit, sequencer, top level and testbench use it.
`timescale 1ns / 1ps

package lfu_kv_pkg;

  // Defaults for the top-level parameters.
  localparam int CAPACITY_DEF    = 16;
  localparam int COUNT_WIDTH_DEF = 16;

  // Fixed field widths.
  localparam int KEY_WIDTH   = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int CFG_WIDTH   = 5;

  localparam logic [CFG_WIDTH-1:0]   CAP_RESET  = 5'd16;
  localparam logic [VALUE_WIDTH-1:0] MISS_VALUE = 32'hFFFF_FFFF;

  // Request kinds.
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  // Controls from the sequencer to the entry store.
  typedef struct packed {
    logic rd_en;
    logic ent_wr;
    logic rank_wr;
    logic insert;
  } store_cmd_t;

  // Controls from the sequencer to the scan unit.
  typedef struct packed {
    logic clear;
    logic sample;
  } scan_cmd_t;

  // Outcome flags of one scan.
  typedef struct packed {
    logic found;
    logic have_victim;
    logic have_free;
  } scan_flags_t;

  // One result word, laid out as it leaves on the output channel.
  typedef struct packed {
    logic [KEY_WIDTH-1:0]   evicted_key;
    logic                   evicted;
    logic [VALUE_WIDTH-1:0] read_value;
    logic                   hit;
  } result_t;

endpackage

[rtl/lfu_key_value_cache.sv]
// Top level of the LFU key/value cache with LRU tie break.
// Instantiates lfu_kv_ctrl, lfu_kv_store and lfu_kv_scan; uses lfu_kv_pkg.
//
// Usage:
//   Requests enter on the s_ stream: s_tuser is the request kind (get or
//   put), s_tdata carries the key and the value to store. One result word
//   per request leaves on the m_ stream: hit, read value, evicted flag and
//   evicted key. cfg_we/cfg_wdata set the capacity in use; write it only
//   while no request is in flight.
//   Each request is handled alone. One shared compare unit walks the
//   entry memories one entry per cycle, so a request costs one scan pass
//   over all CAPACITY entries plus a decision state. A hit or an evicting
//   put adds a rank update pass over the rank memory. Get misses and plain
//   inserts skip that pass, and a request at a capacity in use of zero
//   skips the scan as well and goes straight to its result.
//   The result sits in an output register; a new request is accepted
//   while it waits, and only the next result stalls behind a held one.
//   Reset empties the cache and sets the capacity in use to 16.
`timescale 1ns / 1ps

module lfu_key_value_cache #(
  parameter int CAPACITY    = lfu_kv_pkg::CAPACITY_DEF,
  parameter int COUNT_WIDTH = lfu_kv_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // Capacity register write.
  input  logic                                cfg_we,
  input  logic [lfu_kv_pkg::CFG_WIDTH-1:0]    cfg_wdata,
  // Request stream.
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic                                s_tuser,  // [0] cmd
  input  logic [63:0]                         s_tdata,  // [31:0] key, [63:32] write_value
  // Result stream.
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [0] hit, [32:1] read_value, [33] evicted, [65:34] evicted_key, [71:66] zero
  output logic [71:0]                         m_tdata
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OCC_W = $clog2(CAPACITY + 1);

  logic [lfu_kv_pkg::CFG_WIDTH-1:0] capacity_in_use;
  logic                             cap_zero;
  logic                             cap_full;
  logic [31:0]                      cap_ext;
  logic [31:0]                      cap_lim;

  lfu_kv_pkg::store_cmd_t             store_cmd;
  lfu_kv_pkg::scan_cmd_t              scan_cmd;
  lfu_kv_pkg::scan_flags_t            flags;
  lfu_kv_pkg::result_t                res;
  lfu_kv_pkg::result_t                out_q;
  logic                               res_load;
  logic                               out_free;
  logic [IDX_W-1:0]                   rd_addr;
  logic [IDX_W-1:0]                   wr_addr;
  logic [lfu_kv_pkg::KEY_WIDTH-1:0]   wr_key;
  logic [lfu_kv_pkg::VALUE_WIDTH-1:0] wr_value;
  logic [COUNT_WIDTH-1:0]             wr_count;
  logic [IDX_W-1:0]                   rank_wr_addr;
  logic [IDX_W-1:0]                   rank_wr_data;
  logic                               rd_vld;
  logic [IDX_W-1:0]                   rd_idx;
  logic                               rd_valid;
  logic [lfu_kv_pkg::KEY_WIDTH-1:0]   rd_key;
  logic [lfu_kv_pkg::VALUE_WIDTH-1:0] rd_value;
  logic [COUNT_WIDTH-1:0]             rd_count;
  logic [IDX_W-1:0]                   rd_rank;
  logic [OCC_W-1:0]                   occupancy;
  logic [IDX_W-1:0]                   match_idx;
  logic [lfu_kv_pkg::VALUE_WIDTH-1:0] match_value;
  logic [COUNT_WIDTH-1:0]             match_count;
  logic [IDX_W-1:0]                   match_rank;
  logic [IDX_W-1:0]                   vic_idx;
  logic [lfu_kv_pkg::KEY_WIDTH-1:0]   vic_key;
  logic [IDX_W-1:0]                   vic_rank;
  logic [IDX_W-1:0]                   free_idx;

  // Capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_in_use <= lfu_kv_pkg::CAP_RESET;
    end else if (cfg_we) begin
      capacity_in_use <= cfg_wdata;
    end
  end

  // Effective capacity is clamped to the table size.
  always_comb begin
    cap_ext  = 32'(capacity_in_use);
    cap_lim  = (cap_ext > 32'(CAPACITY)) ? 32'(CAPACITY) : cap_ext;
    cap_zero = (capacity_in_use == '0);
    cap_full = (32'(occupancy) >= cap_lim);
  end

  lfu_kv_ctrl #(
    .CAPACITY    (CAPACITY),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_cmd       (s_tuser),
    .in_key       (s_tdata[31:0]),
    .in_wval      (s_tdata[63:32]),
    .cap_zero     (cap_zero),
    .cap_full     (cap_full),
    .store_cmd    (store_cmd),
    .rd_addr      (rd_addr),
    .wr_addr      (wr_addr),
    .wr_key       (wr_key),
    .wr_value     (wr_value),
    .wr_count     (wr_count),
    .rank_wr_addr (rank_wr_addr),
    .rank_wr_data (rank_wr_data),
    .rd_vld       (rd_vld),
    .rd_idx       (rd_idx),
    .rd_valid     (rd_valid),
    .rd_rank      (rd_rank),
    .occupancy    (occupancy),
    .scan_cmd     (scan_cmd),
    .flags        (flags),
    .match_idx    (match_idx),
    .match_value  (match_value),
    .match_count  (match_count),
    .match_rank   (match_rank),
    .vic_idx      (vic_idx),
    .vic_key      (vic_key),
    .vic_rank     (vic_rank),
    .free_idx     (free_idx),
    .out_free     (out_free),
    .res_load     (res_load),
    .res          (res)
  );

  lfu_kv_store #(
    .CAPACITY    (CAPACITY),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_store (
    .clk          (clk),
    .rst          (rst),
    .cmd          (store_cmd),
    .rd_addr      (rd_addr),
    .wr_addr      (wr_addr),
    .wr_key       (wr_key),
    .wr_value     (wr_value),
    .wr_count     (wr_count),
    .rank_wr_addr (rank_wr_addr),
    .rank_wr_data (rank_wr_data),
    .rd_vld       (rd_vld),
    .rd_idx       (rd_idx),
    .rd_valid     (rd_valid),
    .rd_key       (rd_key),
    .rd_value     (rd_value),
    .rd_count     (rd_count),
    .rd_rank      (rd_rank),
    .occupancy    (occupancy)
  );

  lfu_kv_scan #(
    .CAPACITY    (CAPACITY),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .cmd         (scan_cmd),
    .req_key     (s_tdata_key_q),
    .rd_idx      (rd_idx),
    .rd_valid    (rd_valid),
    .rd_key      (rd_key),
    .rd_value    (rd_value),
    .rd_count    (rd_count),
    .rd_rank     (rd_rank),
    .flags       (flags),
    .match_idx   (match_idx),
    .match_value (match_value),
    .match_count (match_count),
    .match_rank  (match_rank),
    .vic_idx     (vic_idx),
    .vic_key     (vic_key),
    .vic_rank    (vic_rank),
    .free_idx    (free_idx)
  );

  // Key under search, held for the whole scan pass.
  logic [lfu_kv_pkg::KEY_WIDTH-1:0] s_tdata_key_q;

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s_tdata_key_q <= s_tdata[31:0];
    end
  end

  // Output register: loaded when the slot is empty or being taken.
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_q <= res;
    end
  end

  assign m_tdata = {6'b0, out_q};

endmodule

[rtl/lfu_kv_store.sv]
// Entry store of the LFU cache: key, value, count and rank memories,
// per-entry valid bits and the occupancy count. Uses lfu_kv_pkg.
`timescale 1ns / 1ps

module lfu_kv_store #(
  parameter int CAPACITY    = lfu_kv_pkg::CAPACITY_DEF,
  parameter int COUNT_WIDTH = lfu_kv_pkg::COUNT_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  lfu_kv_pkg::store_cmd_t             cmd,
  input  logic [IDX_W-1:0]                   rd_addr,
  input  logic [IDX_W-1:0]                   wr_addr,
  input  logic [lfu_kv_pkg::KEY_WIDTH-1:0]   wr_key,
  input  logic [lfu_kv_pkg::VALUE_WIDTH-1:0] wr_value,
  input  logic [COUNT_WIDTH-1:0]             wr_count,
  input  logic [IDX_W-1:0]                   rank_wr_addr,
  input  logic [IDX_W-1:0]                   rank_wr_data,
  output logic                               rd_vld,
  output logic [IDX_W-1:0]                   rd_idx,
  output logic                               rd_valid,
  output logic [lfu_kv_pkg::KEY_WIDTH-1:0]   rd_key,
  output logic [lfu_kv_pkg::VALUE_WIDTH-1:0] rd_value,
  output logic [COUNT_WIDTH-1:0]             rd_count,
  output logic [IDX_W-1:0]                   rd_rank,
  output logic [OCC_W-1:0]                   occupancy
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OCC_W = $clog2(CAPACITY + 1);

  logic [lfu_kv_pkg::KEY_WIDTH-1:0]   key_mem   [CAPACITY];
  logic [lfu_kv_pkg::VALUE_WIDTH-1:0] value_mem [CAPACITY];
  logic [COUNT_WIDTH-1:0]             count_mem [CAPACITY];
  logic [IDX_W-1:0]                   rank_mem  [CAPACITY];
  logic [CAPACITY-1:0]                valid;

  // Key, value and count share one write port and one read port.
  always_ff @(posedge clk) begin
    if (cmd.ent_wr) begin
      key_mem[wr_addr]   <= wr_key;
      value_mem[wr_addr] <= wr_value;
      count_mem[wr_addr] <= wr_count;
    end
    if (cmd.rd_en) begin
      rd_key   <= key_mem[rd_addr];
      rd_value <= value_mem[rd_addr];
      rd_count <= count_mem[rd_addr];
    end
  end

  // The rank memory has its own write port for inserts and the rank update pass.
  always_ff @(posedge clk) begin
    if (cmd.rank_wr) begin
      rank_mem[rank_wr_addr] <= rank_wr_data;
    end
    if (cmd.rd_en) begin
      rd_rank <= rank_mem[rd_addr];
    end
  end

  // Read tag: which entry the registered read data belongs to.
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_idx   <= rd_addr;
      rd_valid <= valid[rd_addr];
    end
  end

  // Valid bits, read strobe and occupancy are cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      rd_vld    <= 1'b0;
      occupancy <= '0;
    end else begin
      rd_vld <= cmd.rd_en;
      if (cmd.insert) begin
        valid[wr_addr] <= 1'b1;
        occupancy      <= occupancy + 1'b1;
      end
    end
  end

endmodule

[rtl/lfu_kv_scan.sv]
// Shared compare unit of the LFU cache: one entry per cycle it checks
// for a key match, the eviction victim and the lowest free slot. Uses lfu_kv_pkg.
`timescale 1ns / 1ps

module lfu_kv_scan #(
  parameter int CAPACITY    = lfu_kv_pkg::CAPACITY_DEF,
  parameter int COUNT_WIDTH = lfu_kv_pkg::COUNT_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  lfu_kv_pkg::scan_cmd_t              cmd,
  input  logic [lfu_kv_pkg::KEY_WIDTH-1:0]   req_key,
  input  logic [IDX_W-1:0]                   rd_idx,
  input  logic                               rd_valid,
  input  logic [lfu_kv_pkg::KEY_WIDTH-1:0]   rd_key,
  input  logic [lfu_kv_pkg::VALUE_WIDTH-1:0] rd_value,
  input  logic [COUNT_WIDTH-1:0]             rd_count,
  input  logic [IDX_W-1:0]                   rd_rank,
  output lfu_kv_pkg::scan_flags_t            flags,
  output logic [IDX_W-1:0]                   match_idx,
  output logic [lfu_kv_pkg::VALUE_WIDTH-1:0] match_value,
  output logic [COUNT_WIDTH-1:0]             match_count,
  output logic [IDX_W-1:0]                   match_rank,
  output logic [IDX_W-1:0]                   vic_idx,
  output logic [lfu_kv_pkg::KEY_WIDTH-1:0]   vic_key,
  output logic [IDX_W-1:0]                   vic_rank,
  output logic [IDX_W-1:0]                   free_idx
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [COUNT_WIDTH-1:0] vic_count;
  logic                   take_match;
  logic                   take_victim;
  logic                   take_free;

  // Compare the entry on the read port against the request and the best so far.
  always_comb begin
    take_match  = rd_valid && !flags.found && (rd_key == req_key);
    take_victim = rd_valid && (!flags.have_victim || (rd_count < vic_count) ||
                  ((rd_count == vic_count) && (rd_rank < vic_rank)));
    take_free   = !rd_valid && !flags.have_free;
  end

  // Outcome flags restart with every request.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      flags <= '0;
    end else if (cmd.sample) begin
      if (take_match) flags.found <= 1'b1;
      if (take_victim) flags.have_victim <= 1'b1;
      if (take_free) flags.have_free <= 1'b1;
    end
  end

  // Captured entry data for the match, the victim and the free slot.
  always_ff @(posedge clk) begin
    if (cmd.sample) begin
      if (take_match) begin
        match_idx   <= rd_idx;
        match_value <= rd_value;
        match_count <= rd_count;
        match_rank  <= rd_rank;
      end
      if (take_victim) begin
        vic_idx   <= rd_idx;
        vic_key   <= rd_key;
        vic_count <= rd_count;
        vic_rank  <= rd_rank;
      end
      if (take_free) begin
        free_idx <= rd_idx;
      end
    end
  end

endmodule

[rtl/lfu_kv_ctrl.sv]
// Sequencer of the LFU cache: scan pass, decision, rank update pass and
// result hand-off. Drives lfu_kv_store and lfu_kv_scan. Uses lfu_kv_pkg.
`timescale 1ns / 1ps

module lfu_kv_ctrl #(
  parameter int CAPACITY    = lfu_kv_pkg::CAPACITY_DEF,
  parameter int COUNT_WIDTH = lfu_kv_pkg::COUNT_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // Request side.
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_cmd,
  input  logic [lfu_kv_pkg::KEY_WIDTH-1:0]   in_key,
  input  logic [lfu_kv_pkg::VALUE_WIDTH-1:0] in_wval,
  // Capacity status.
  input  logic                               cap_zero,
  input  logic                               cap_full,
  // Store.
  output lfu_kv_pkg::store_cmd_t             store_cmd,
  output logic [IDX_W-1:0]                   rd_addr,
  output logic [IDX_W-1:0]                   wr_addr,
  output logic [lfu_kv_pkg::KEY_WIDTH-1:0]   wr_key,
  output logic [lfu_kv_pkg::VALUE_WIDTH-1:0] wr_value,
  output logic [COUNT_WIDTH-1:0]             wr_count,
  output logic [IDX_W-1:0]                   rank_wr_addr,
  output logic [IDX_W-1:0]                   rank_wr_data,
  input  logic                               rd_vld,
  input  logic [IDX_W-1:0]                   rd_idx,
  input  logic                               rd_valid,
  input  logic [IDX_W-1:0]                   rd_rank,
  input  logic [OCC_W-1:0]                   occupancy,
  // Scan unit.
  output lfu_kv_pkg::scan_cmd_t              scan_cmd,
  input  lfu_kv_pkg::scan_flags_t            flags,
  input  logic [IDX_W-1:0]                   match_idx,
  input  logic [lfu_kv_pkg::VALUE_WIDTH-1:0] match_value,
  input  logic [COUNT_WIDTH-1:0]             match_count,
  input  logic [IDX_W-1:0]                   match_rank,
  input  logic [IDX_W-1:0]                   vic_idx,
  input  logic [lfu_kv_pkg::KEY_WIDTH-1:0]   vic_key,
  input  logic [IDX_W-1:0]                   vic_rank,
  input  logic [IDX_W-1:0]                   free_idx,
  // Result hand-off.
  input  logic                               out_free,
  output logic                               res_load,
  output lfu_kv_pkg::result_t                res
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OCC_W = $clog2(CAPACITY + 1);
  localparam logic [OCC_W-1:0] PTR_END = OCC_W'(CAPACITY);

  lfu_kv_pkg::state_t state, state_next;

  logic [OCC_W-1:0]                   ptr;
  logic                               req_cmd;
  logic [lfu_kv_pkg::KEY_WIDTH-1:0]   req_key;
  logic [lfu_kv_pkg::VALUE_WIDTH-1:0] req_wval;
  logic [IDX_W-1:0]                   slot;
  logic [IDX_W-1:0]                   old_rank;

  logic                   is_put;
  logic                   do_evict;
  logic                   do_insert;
  logic                   do_touch;
  logic [COUNT_WIDTH-1:0] bumped_count;

  // Decision terms, valid once the scan pass is complete.
  always_comb begin
    is_put       = (req_cmd == lfu_kv_pkg::CMD_PUT);
    do_evict     = !flags.found && is_put && cap_full && flags.have_victim;
    do_insert    = !flags.found && is_put && !cap_full && flags.have_free;
    do_touch     = flags.found || do_evict;
    bumped_count = (&match_count) ? match_count : match_count + 1'b1;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      lfu_kv_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = cap_zero ? lfu_kv_pkg::ST_FINISH : lfu_kv_pkg::ST_SCAN;
        end
      end
      lfu_kv_pkg::ST_SCAN: begin
        if (ptr == PTR_END) state_next = lfu_kv_pkg::ST_DECIDE;
      end
      lfu_kv_pkg::ST_DECIDE: begin
        state_next = do_touch ? lfu_kv_pkg::ST_UPDATE : lfu_kv_pkg::ST_FINISH;
      end
      lfu_kv_pkg::ST_UPDATE: begin
        if (ptr == PTR_END) state_next = lfu_kv_pkg::ST_FINISH;
      end
      lfu_kv_pkg::ST_FINISH: begin
        if (out_free) state_next = lfu_kv_pkg::ST_IDLE;
      end
      default: state_next = lfu_kv_pkg::ST_IDLE;
    endcase
  end

  // Outputs toward the store, the scan unit and the result register.
  always_comb begin
    in_ready     = 1'b0;
    store_cmd    = '0;
    scan_cmd     = '0;
    res_load     = 1'b0;
    rd_addr      = ptr[IDX_W-1:0];
    wr_addr      = free_idx;
    wr_key       = req_key;
    wr_value     = req_wval;
    wr_count     = COUNT_WIDTH'(1);
    rank_wr_addr = rd_idx;
    rank_wr_data = IDX_W'(occupancy - 1'b1);
    case (state)
      lfu_kv_pkg::ST_IDLE: begin
        in_ready       = 1'b1;
        scan_cmd.clear = in_valid;
      end
      lfu_kv_pkg::ST_SCAN: begin
        store_cmd.rd_en = (ptr != PTR_END);
        scan_cmd.sample = rd_vld;
      end
      lfu_kv_pkg::ST_DECIDE: begin
        if (flags.found) begin
          store_cmd.ent_wr = 1'b1;
          wr_addr          = match_idx;
          wr_value         = is_put ? req_wval : match_value;
          wr_count         = bumped_count;
        end else if (do_evict) begin
          store_cmd.ent_wr = 1'b1;
          wr_addr          = vic_idx;
        end else if (do_insert) begin
          store_cmd.ent_wr  = 1'b1;
          store_cmd.insert  = 1'b1;
          store_cmd.rank_wr = 1'b1;
          rank_wr_addr      = free_idx;
          rank_wr_data      = IDX_W'(occupancy);
        end
      end
      lfu_kv_pkg::ST_UPDATE: begin
        // Touched slot becomes newest; newer entries move down one rank.
        store_cmd.rd_en = (ptr != PTR_END);
        if (rd_vld) begin
          if (rd_idx == slot) begin
            store_cmd.rank_wr = 1'b1;
          end else if (rd_valid && (rd_rank > old_rank)) begin
            store_cmd.rank_wr = 1'b1;
            rank_wr_data      = rd_rank - 1'b1;
          end
        end
      end
      lfu_kv_pkg::ST_FINISH: begin
        res_load = out_free;
      end
      default: begin
      end
    endcase
  end

  // State and pass pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lfu_kv_pkg::ST_IDLE;
      ptr   <= '0;
    end else begin
      state <= state_next;
      if ((state == lfu_kv_pkg::ST_SCAN || state == lfu_kv_pkg::ST_UPDATE) &&
          (ptr != PTR_END)) begin
        ptr <= ptr + 1'b1;
      end else begin
        ptr <= '0;
      end
    end
  end

  // Request word, touched slot and pending result.
  always_ff @(posedge clk) begin
    if (state == lfu_kv_pkg::ST_IDLE && in_valid) begin
      req_cmd        <= in_cmd;
      req_key        <= in_key;
      req_wval       <= in_wval;
      res.hit        <= 1'b0;
      res.read_value <= lfu_kv_pkg::MISS_VALUE;
      res.evicted    <= 1'b0;
      res.evicted_key <= '0;
    end
    if (state == lfu_kv_pkg::ST_DECIDE) begin
      if (flags.found) begin
        slot     <= match_idx;
        old_rank <= match_rank;
        res.hit  <= 1'b1;
        if (!is_put) res.read_value <= match_value;
      end else if (do_evict) begin
        slot            <= vic_idx;
        old_rank        <= vic_rank;
        res.evicted     <= 1'b1;
        res.evicted_key <= vic_key;
      end
    end
  end

endmodule

[rtl/lfu_kv_checker.sv]
// Port-level checker for the LFU key/value cache, bound to the top level.
// Uses the assertion macros of lfu_key_value_cache_macros.svh.
`timescale 1ns / 1ps
`include "lfu_key_value_cache_macros.svh"

module lfu_kv_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_we,
  input logic [4:0]  cfg_wdata,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tuser,
  input logic [63:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata
);

  // A held result word must not change or vanish.
  `LFU_KV_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // Requests are handled one at a time: no acceptance right after one.
  `LFU_KV_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)

  // An eviction only comes from a put miss, which reads as a miss.
  `LFU_KV_ASSERT_NOW(a_evict_is_miss, m_tvalid && m_tdata[33],
                     !m_tdata[0] && (m_tdata[32:1] == 32'hFFFF_FFFF))

  // Without an eviction the evicted key reads as zero.
  `LFU_KV_ASSERT_NOW(a_evkey_zero, m_tvalid && !m_tdata[33], m_tdata[65:34] == 32'd0)

endmodule

bind lfu_key_value_cache lfu_kv_checker u_lfu_kv_checker (.*);

[sim/lfu_key_value_cache_tb.sv]
// Self-checking testbench for the LFU key/value cache: a directed table, then random phases
// at several capacities, each result checked against its typed row or else a model kept here.
// Depends on lfu_kv_pkg and lfu_key_value_cache.
`timescale 1ns / 1ps

module lfu_key_value_cache_tb;
  import lfu_kv_pkg::*;

  // A narrow use count lets the random traffic drive hot keys into saturation.
  localparam int NUM_SLOTS = CAPACITY_DEF;
  localparam int USE_BITS  = 4;
  localparam int PHASE_ITEMS = 45;
  localparam int LONG_HOLD_AT = 130;
  localparam int LONG_HOLD_CYCLES = 400;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_WIDTH-1:0] cfg_wdata;
  logic                 s_tvalid;
  logic                 s_tready;
  logic                 s_tuser;
  logic [63:0]          s_tdata;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [71:0]          m_tdata;

  lfu_key_value_cache #(
    .CAPACITY    (NUM_SLOTS),
    .COUNT_WIDTH (USE_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // One row of the directed table: either a capacity write or a request.
  typedef struct packed {
    logic                 set_cap;
    logic [CFG_WIDTH-1:0] cap;
    logic                 cmd;
    logic [31:0]          key;
    logic [31:0]          wval;
    logic                 typed;
    result_t              want;
  } dir_row_t;

  localparam result_t MISS_RES = '{evicted_key: '0, evicted: 1'b0,
                                   read_value: MISS_VALUE, hit: 1'b0};
  localparam result_t PUT_HIT_RES = '{evicted_key: '0, evicted: 1'b0,
                                      read_value: MISS_VALUE, hit: 1'b1};

  localparam int DIR_N = 23;
  localparam dir_row_t DIR_ROWS [0:DIR_N-1] = '{
    // Empty cache after reset, extreme keys and values.
    '{1'b0, 5'd0, CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, MISS_RES},
    '{1'b0, 5'd0, CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, MISS_RES},
    '{1'b0, 5'd0, CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1,
      '{32'h0, 1'b0, 32'h8000_0000, 1'b1}},
    '{1'b0, 5'd0, CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, MISS_RES},
    // A put on a present key replaces the value and reports no read value.
    '{1'b0, 5'd0, CMD_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, PUT_HIT_RES},
    '{1'b0, 5'd0, CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1,
      '{32'h0, 1'b0, 32'h7FFF_FFFF, 1'b1}},
    '{1'b0, 5'd0, CMD_GET, 32'h7FFF_FFFF, 32'h1234_5678, 1'b1,
      '{32'h0, 1'b0, 32'hFFFF_FFFF, 1'b1}},
    '{1'b0, 5'd0, CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, MISS_RES},
    // Capacity zero: everything misses and nothing changes.
    '{1'b1, 5'd0, CMD_GET, 32'h0, 32'h0, 1'b0, MISS_RES},
    '{1'b0, 5'd0, CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, MISS_RES},
    '{1'b0, 5'd0, CMD_PUT, 32'h0000_0001, 32'h0000_0001, 1'b1, MISS_RES},
    // Capacity lowered below occupancy: a new key evicts the least used.
    '{1'b1, 5'd1, CMD_GET, 32'h0, 32'h0, 1'b0, MISS_RES},
    '{1'b0, 5'd0, CMD_PUT, 32'h0000_0000, 32'h0000_0000, 1'b0, MISS_RES},
    '{1'b0, 5'd0, CMD_GET, 32'h8000_0000, 32'h0000_0000, 1'b0, MISS_RES},
    '{1'b0, 5'd0, CMD_PUT, 32'hFFFF_FFFF, 32'h5555_AAAA, 1'b0, MISS_RES},
    '{1'b0, 5'd0, CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, MISS_RES},
    // Capacity above the table size acts as the table size.
    '{1'b1, 5'd31, CMD_GET, 32'h0, 32'h0, 1'b0, MISS_RES},
    '{1'b0, 5'd0, CMD_PUT, 32'h0000_0001, 32'hAAAA_5555, 1'b0, MISS_RES},
    '{1'b0, 5'd0, CMD_PUT, 32'h0000_0002, 32'h0F0F_F0F0, 1'b0, MISS_RES},
    '{1'b0, 5'd0, CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, MISS_RES},
    // Equal counts: the entry touched longest ago goes first.
    '{1'b1, 5'd2, CMD_GET, 32'h0, 32'h0, 1'b0, MISS_RES},
    '{1'b0, 5'd0, CMD_PUT, 32'h0000_0003, 32'h3333_3333, 1'b0, MISS_RES},
    '{1'b0, 5'd0, CMD_PUT, 32'h0000_0004, 32'h4444_4444, 1'b0, MISS_RES}
  };

  // Model state of the cache.
  logic                 cache_valid [NUM_SLOTS];
  logic [31:0]          cache_key   [NUM_SLOTS];
  logic [31:0]          cache_val   [NUM_SLOTS];
  logic [USE_BITS-1:0]  cache_uses  [NUM_SLOTS];
  logic [3:0]           cache_age   [NUM_SLOTS];
  logic [4:0]           cache_fill;
  logic [CFG_WIDTH-1:0] cap_reg;

  result_t expected_results [$];
  int      errors;
  int      results_seen;
  bit      quiet;
  bit      long_hold_done;
  logic [31:0] hot_key;

  // Make slot s the newest; entries newer than it age by one.
  function automatic void promote_slot(input int s);
    logic [3:0] old;
    old = cache_age[s];
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (cache_valid[i] && cache_age[i] > old) cache_age[i] = cache_age[i] - 4'd1;
    end
    cache_age[s] = 4'(cache_fill - 5'd1);
  endfunction

  // Remove slot s; entries newer than it move down one rank.
  function automatic void drop_slot(input int s);
    logic [3:0] old;
    old = cache_age[s];
    cache_valid[s] = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (cache_valid[i] && cache_age[i] > old) cache_age[i] = cache_age[i] - 4'd1;
    end
    cache_fill = cache_fill - 5'd1;
  endfunction

  // Apply one request to the model and return the result word it must produce.
  function automatic result_t predict_access(input logic cmd, input logic [31:0] key,
                                             input logic [31:0] wval);
    result_t r;
    int      lim;
    int      slot;
    int      victim;
    logic    found;
    logic    have;
    r = MISS_RES;
    lim = (int'(cap_reg) > NUM_SLOTS) ? NUM_SLOTS : int'(cap_reg);
    if (lim == 0) return r;
    found = 1'b0;
    slot = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (!found && cache_valid[i] && cache_key[i] == key) begin
        found = 1'b1;
        slot = i;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      if (cmd == CMD_GET) r.read_value = cache_val[slot];
      else cache_val[slot] = wval;
      if (cache_uses[slot] != '1) cache_uses[slot] = cache_uses[slot] + 1'b1;
      promote_slot(slot);
    end else if (cmd == CMD_PUT) begin
      have = 1'b0;
      if (int'(cache_fill) >= lim) begin
        victim = 0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (cache_valid[i] && (!have || cache_uses[i] < cache_uses[victim] ||
              (cache_uses[i] == cache_uses[victim] && cache_age[i] < cache_age[victim]))) begin
            victim = i;
            have = 1'b1;
          end
        end
        if (have) begin
          r.evicted = 1'b1;
          r.evicted_key = cache_key[victim];
          drop_slot(victim);
          slot = victim;
        end
      end
      // Without a victim the new key takes the lowest free slot.
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
        if (!have && !cache_valid[i]) slot = i;
      end
      cache_valid[slot] = 1'b1;
      cache_key[slot] = key;
      cache_val[slot] = wval;
      cache_uses[slot] = 1;
      cache_fill = cache_fill + 5'd1;
      cache_age[slot] = 4'(cache_fill - 5'd1);
    end
    return r;
  endfunction

  // Offer one request word after a random gap and record its expected result.
  task automatic send_req(input logic cmd, input logic [31:0] key, input logic [31:0] wval,
                          input logic typed, input result_t want);
    int      gap;
    result_t pred;
    gap = quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {wval, key};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pred = predict_access(cmd, key, wval);
    expected_results.push_back(typed ? want : pred);
  endtask

  // Write the capacity once every result is out and the block has settled.
  task automatic set_capacity(input logic [CFG_WIDTH-1:0] cap);
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    cap_reg = cap;
  endtask

  // Random requests over a small key pool so that hits and evictions are frequent.
  task automatic run_phase(input logic [CFG_WIDTH-1:0] cap);
    logic [31:0] pool [24];
    int          pool_n;
    int          roll;
    logic [31:0] k;
    pool_n = $urandom_range(3, 24);
    foreach (pool[i]) pool[i] = $urandom;
    pool[0] = hot_key;
    pool[1] = 32'h8000_0000;
    pool[pool_n - 1] = 32'h7FFF_FFFF;
    quiet = ($urandom_range(0, 3) == 0);
    set_capacity(cap);
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      roll = $urandom_range(0, 9);
      if (roll == 0) k = $urandom;
      else if (roll < 4) k = pool[0];
      else k = pool[$urandom_range(0, pool_n - 1)];
      send_req(1'($urandom_range(0, 1)), k, $urandom, 1'b0, MISS_RES);
    end
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  // Result side: random hold-offs per word, plus one long stall.
  initial begin
    int n;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    m_tready <= 1'b1;
    forever begin
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      n = quiet ? 0 : $urandom_range(0, 8);
      if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
        n = LONG_HOLD_CYCLES;
        long_hold_done = 1'b1;
      end
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
        m_tready <= 1'b1;
      end
    end
  end

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk) begin
    result_t act;
    result_t exp_res;
    if (!rst && m_tvalid && m_tready) begin
      act = m_tdata[65:0];
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("unexpected result word: %h", m_tdata);
        errors++;
      end else begin
        exp_res = expected_results.pop_front();
        if (act.hit !== exp_res.hit) begin
          $error("hit: expected %0d, got %0d", exp_res.hit, act.hit);
          errors++;
        end
        if (act.read_value !== exp_res.read_value) begin
          $error("read_value: expected %h, got %h", exp_res.read_value, act.read_value);
          errors++;
        end
        if (act.evicted !== exp_res.evicted) begin
          $error("evicted: expected %0d, got %0d", exp_res.evicted, act.evicted);
          errors++;
        end
        if (act.evicted_key !== exp_res.evicted_key) begin
          $error("evicted_key: expected %h, got %h", exp_res.evicted_key, act.evicted_key);
          errors++;
        end
      end
    end
  end

  // Stimulus: reset, directed table, random phases, drain.
  initial begin
    logic [CFG_WIDTH-1:0] caps [10];
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    s_tvalid  <= 1'b0;
    s_tuser   <= CMD_GET;
    s_tdata   <= '0;
    errors = 0;
    results_seen = 0;
    quiet = 1'b0;
    long_hold_done = 1'b0;
    hot_key = $urandom;
    foreach (cache_valid[i]) begin
      cache_valid[i] = 1'b0;
      cache_key[i] = '0;
      cache_val[i] = '0;
      cache_uses[i] = '0;
      cache_age[i] = '0;
    end
    cache_fill = '0;
    cap_reg = CAP_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++) begin
      if (DIR_ROWS[i].set_cap) set_capacity(DIR_ROWS[i].cap);
      else send_req(DIR_ROWS[i].cmd, DIR_ROWS[i].key, DIR_ROWS[i].wval,
                    DIR_ROWS[i].typed, DIR_ROWS[i].want);
    end

    caps = '{5'd16, 5'd2, 5'd0, 5'd31, 5'd1, 5'd5, 5'd17, 5'd0, 5'd16, 5'd3};
    caps[7] = 5'($urandom_range(0, 31));
    foreach (caps[p]) run_phase(caps[p]);

    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
